/* rtl/pip_pkg.sv */
// types and constants shared by the palette index packer
`default_nettype none

package pip_pkg;

  localparam int unsigned PAL_SLOTS = 4;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned COLOUR_W  = 32;
  localparam int unsigned COUNT_W   = 3;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // register indexes
  localparam logic REG_FIRST_TRANSPARENT = 1'b0;

  typedef struct packed {
    logic [COLOUR_W-1:0] pixel_colour;
    logic                pixel_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [7:0]          packed_byte;
    logic [SLOT_W-1:0]   palette_slot;
    logic [COLOUR_W-1:0] palette_colour;
    logic                result_last;
  } out_item_t;

  typedef logic [PAL_SLOTS-1:0][COLOUR_W-1:0] palette_t;

  // results caused by one pixel, handed from the packer to the emitter
  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_val;
    logic       has_error;
    logic       has_palette;
    palette_t   colours;
  } job_t;

endpackage

`default_nettype wire

/* rtl/pip_pack.sv */
// palette lookup, index packing and per-image state
`default_nettype none

module pip_pack (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire pip_pkg::in_item_t item,
  input  wire logic             first_transparent,
  output pip_pkg::job_t         job
);

  logic                                  image_open;
  logic                                  slot0_reserved;
  logic [pip_pkg::COUNT_W-1:0]           colour_count;
  pip_pkg::palette_t                     palette_store;
  logic [7:0]                            pack_accumulator;
  logic [1:0]                            pack_position;
  logic                                  failed_flag;

  logic                                  image_open_next;
  logic                                  slot0_reserved_next;
  logic [pip_pkg::COUNT_W-1:0]           colour_count_next;
  pip_pkg::palette_t                     palette_store_next;
  logic [7:0]                            pack_accumulator_next;
  logic [1:0]                            pack_position_next;
  logic                                  failed_flag_next;

  always_comb begin
    logic                        res0;
    logic [pip_pkg::COUNT_W-1:0] cnt0;
    pip_pkg::palette_t           pal0;
    logic [7:0]                  acc0;
    logic [1:0]                  pos0;
    logic                        fail0;
    logic                        found;
    logic [1:0]                  idx;
    logic                        err;
    logic                        add_new;
    logic [7:0]                  new_acc;
    logic                        full;
    logic                        ok;

    // first pixel of an image starts from cleared state, with slot 0 held back when first_transparent is set
    res0  = image_open ? slot0_reserved : first_transparent;
    cnt0  = image_open ? colour_count : {{(pip_pkg::COUNT_W-1){1'b0}}, first_transparent};
    pal0  = image_open ? palette_store : '0;
    acc0  = image_open ? pack_accumulator : 8'd0;
    pos0  = image_open ? pack_position : 2'd0;
    fail0 = image_open ? failed_flag : 1'b0;

    found = 1'b0;
    idx   = 2'd0;
    for (int j = 0; j < pip_pkg::PAL_SLOTS; j++) begin
      if (!found && ((j != 0) || !res0) && (pip_pkg::COUNT_W'(j) < cnt0) &&
          (pal0[j] == item.pixel_colour)) begin
        found = 1'b1;
        idx   = pip_pkg::SLOT_W'(j);
      end
    end

    err     = !fail0 && !found && (cnt0 >= pip_pkg::COUNT_W'(pip_pkg::PAL_SLOTS));
    add_new = !fail0 && !found && !err;
    if (add_new) begin
      idx = cnt0[pip_pkg::SLOT_W-1:0];
    end
    ok = !fail0 && !err;

    // first pixel lands in bits 7:6
    new_acc = acc0 | (8'(idx) << {~pos0, 1'b0});
    full    = (pos0 == 2'd3);

    palette_store_next = pal0;
    if (add_new) begin
      palette_store_next[cnt0[pip_pkg::SLOT_W-1:0]] = item.pixel_colour;
    end
    colour_count_next   = add_new ? cnt0 + 1'b1 : cnt0;
    slot0_reserved_next = res0;
    failed_flag_next    = fail0 | err;
    if (ok) begin
      pack_accumulator_next = full ? 8'd0 : new_acc;
      pack_position_next    = pos0 + 1'b1;
    end else begin
      pack_accumulator_next = 8'd0;
      pack_position_next    = 2'd0;
    end
    image_open_next = !item.pixel_last;

    job.has_byte    = ok && (full || item.pixel_last);
    job.byte_val    = new_acc;
    job.has_error   = err;
    job.has_palette = ok && item.pixel_last;
    job.colours     = palette_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_open     <= 1'b0;
      slot0_reserved <= 1'b0;
      colour_count   <= '0;
      pack_position  <= 2'd0;
      failed_flag    <= 1'b0;
    end else if (fire) begin
      image_open     <= image_open_next;
      slot0_reserved <= slot0_reserved_next;
      colour_count   <= colour_count_next;
      pack_position  <= pack_position_next;
      failed_flag    <= failed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      palette_store    <= palette_store_next;
      pack_accumulator <= pack_accumulator_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/pip_emit.sv */
// result register that sends the results of one pixel one transfer at a time
`default_nettype none

module pip_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  input  wire pip_pkg::job_t      job,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pip_pkg::out_item_t      out_item
);

  logic                      has_byte;
  logic                      has_error;
  logic                      has_palette;
  logic [7:0]                byte_val;
  pip_pkg::palette_t         colours;
  logic [pip_pkg::SLOT_W-1:0] slot;

  logic take;
  logic final_one;

  assign out_valid = has_byte | has_error | has_palette;
  assign take      = out_valid & !out_stall;

  always_comb begin
    if (has_byte) begin
      final_one = !has_palette;
    end else if (has_error) begin
      final_one = 1'b1;
    end else begin
      final_one = (slot == pip_pkg::SLOT_W'(pip_pkg::PAL_SLOTS - 1));
    end
  end

  assign free = !out_valid | (take & final_one);

  always_comb begin
    out_item = '0;
    if (has_byte) begin
      out_item.result_kind = pip_pkg::KIND_BYTE;
      out_item.packed_byte = byte_val;
    end else if (has_error) begin
      out_item.result_kind = pip_pkg::KIND_ERROR;
      out_item.result_last = 1'b1;
    end else begin
      out_item.result_kind    = pip_pkg::KIND_PALETTE;
      out_item.palette_slot   = slot;
      out_item.palette_colour = colours[slot];
      out_item.result_last    = final_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_byte    <= 1'b0;
      has_error   <= 1'b0;
      has_palette <= 1'b0;
      slot        <= '0;
    end else if (free) begin
      has_byte    <= job_valid & job.has_byte;
      has_error   <= job_valid & job.has_error;
      has_palette <= job_valid & job.has_palette;
      slot        <= '0;
    end else if (take) begin
      if (has_byte) begin
        has_byte <= 1'b0;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free && job_valid) begin
      byte_val <= job.byte_val;
      colours  <= job.colours;
    end
  end

endmodule

`default_nettype wire

/* rtl/palette_index_packer_2bpp.sv */
// Packs 32-bit pixels into 2-bit palette indices, four to a byte, first pixel in bits 7:6,
// building a palette of up to four colours per image (slot 0 held back as transparent when
// first_transparent is set at the image's first pixel). A pixel is taken every clock while
// in_stall is low, and its first result is offered from the result register once the pixel
// has passed through the input register. The last pixel of an image produces up to five
// transfers (a byte and the four palette slots), one per cycle from the result register
// while out_stall is low, so the next pixel waits in the input register meanwhile.
// A fifth distinct colour gives one error transfer marked last, and the image's remaining
// pixels give nothing. first_transparent sits at byte address 0 of the APB port.
`default_nettype none

module palette_index_packer_2bpp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pip_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pip_pkg::out_item_t       out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic              first_transparent;
  logic              s0_valid;
  pip_pkg::in_item_t s0_item;
  logic              free;
  logic              fire;
  pip_pkg::job_t     job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pip_pkg::REG_FIRST_TRANSPARENT) ?
                  {31'd0, first_transparent} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_transparent <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pip_pkg::REG_FIRST_TRANSPARENT) begin
      first_transparent <= pwdata[0];
    end
  end

  // input register
  assign fire     = s0_valid & free;
  assign in_stall = s0_valid & !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!in_stall) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_item <= in_item;
    end
  end

  pip_pack u_pack (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .item              (s0_item),
    .first_transparent (first_transparent),
    .job               (job)
  );

  pip_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (fire),
    .job       (job),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* bench/palette_index_packer_2bpp_tb.sv */
// self-checking testbench for the 2bpp palette index packer
`default_nettype none

module palette_index_packer_2bpp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_PIXELS  = 410;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [2:0] ADDR_FIRST_TRANSPARENT = 3'(4 * pip_pkg::REG_FIRST_TRANSPARENT);
  localparam logic [2:0] ADDR_UNUSED            = 3'd4;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pip_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pip_pkg::out_item_t out_item;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  palette_index_packer_2bpp u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pixels waiting to be sent and results the packer still owes
  pip_pkg::in_item_t  pixels_to_send[$];
  pip_pkg::out_item_t packer_results[$];

  // predictor state
  logic [pip_pkg::COLOUR_W-1:0] pal_colours [pip_pkg::PAL_SLOTS];
  logic [pip_pkg::COUNT_W-1:0]  pal_used = '0;
  logic [7:0]                   pack_bits = '0;
  logic [1:0]                   pack_slot = '0;
  bit                           image_failed = 1'b0;
  bit                           image_running = 1'b0;
  bit                           slot0_held = 1'b0;
  bit                           cfg_transparent = 1'b0;

  int unsigned pixels_queued = 0;
  int unsigned pixels_taken = 0;
  int unsigned mismatches = 0;
  int unsigned byte_results = 0;
  int unsigned palette_results = 0;
  int unsigned error_results = 0;
  int unsigned images_closed = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned cycle_count = 0;

  function automatic pip_pkg::out_item_t packer_result(logic [1:0] kind, logic [7:0] bits,
                                                       logic [1:0] slot, logic [31:0] colour,
                                                       logic last);
    pip_pkg::out_item_t r;
    r.result_kind    = kind;
    r.packed_byte    = bits;
    r.palette_slot   = slot;
    r.palette_colour = colour;
    r.result_last    = last;
    return r;
  endfunction

  // maps one pixel to its index and queues whatever results it causes
  task automatic pack_pixel(input pip_pkg::in_item_t px);
    int unsigned j;
    logic [1:0]  idx;
    bit          found;
    idx = '0;
    found = 1'b0;
    if (!image_running) begin
      foreach (pal_colours[k]) pal_colours[k] = '0;
      slot0_held = cfg_transparent;
      pal_used = pip_pkg::COUNT_W'(slot0_held);
      pack_bits = '0;
      pack_slot = '0;
      image_failed = 1'b0;
      image_running = 1'b1;
    end
    if (!image_failed) begin
      for (j = slot0_held; j < pal_used; j++) begin
        if (!found && pal_colours[j] == px.pixel_colour) begin
          idx = j[1:0];
          found = 1'b1;
        end
      end
      if (!found) begin
        if (pal_used >= pip_pkg::PAL_SLOTS) begin
          image_failed = 1'b1;
          pack_bits = '0;
          pack_slot = '0;
          packer_results.push_back(packer_result(pip_pkg::KIND_ERROR, '0, '0, '0, 1'b1));
        end else begin
          idx = pal_used[1:0];
          pal_colours[idx] = px.pixel_colour;
          pal_used++;
        end
      end
      if (!image_failed) begin
        pack_bits = pack_bits | (8'(idx) << (6 - 2 * int'(pack_slot)));
        if (pack_slot == 2'd3) begin
          packer_results.push_back(packer_result(pip_pkg::KIND_BYTE, pack_bits, '0, '0,
                                                 1'b0));
          pack_bits = '0;
          pack_slot = '0;
        end else begin
          pack_slot++;
        end
        if (px.pixel_last) begin
          // zero-filled partial byte goes out ahead of the palette
          if (pack_slot != 2'd0) begin
            packer_results.push_back(packer_result(pip_pkg::KIND_BYTE, pack_bits, '0, '0,
                                                   1'b0));
            pack_bits = '0;
            pack_slot = '0;
          end
          for (j = 0; j < pip_pkg::PAL_SLOTS; j++)
            packer_results.push_back(packer_result(pip_pkg::KIND_PALETTE, '0, j[1:0],
                                                   pal_colours[j],
                                                   j == pip_pkg::PAL_SLOTS - 1));
        end
      end
    end
    if (px.pixel_last)
      image_running = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input pip_pkg::out_item_t want,
                               input pip_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s): expected kind=%0d byte=%02h slot=%0d colour=%08h last=%0b",
               what, want.result_kind, want.packed_byte, want.palette_slot,
               want.palette_colour, want.result_last);
      $display("  got kind=%0d byte=%02h slot=%0d colour=%08h last=%0b",
               got.result_kind, got.packed_byte, got.palette_slot, got.palette_colour,
               got.result_last);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    logic              offer;
    pip_pkg::in_item_t next_px;
    offer = in_valid;
    next_px = in_item;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pack_pixel(in_item);
        pixels_taken++;
        offer = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixels_to_send.size() > 0) begin
          next_px = pixels_to_send.pop_front();
          offer = 1'b1;
        end
      end
    end
    in_valid <= offer;
    in_item <= next_px;
  end

  // receiver: stall pattern changes at random intervals, plus requested long holds
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    logic stall_next;
    stall_next = 1'b0;
    if (!rst) begin
      if (hold_left == 0 && holds_done < hold_requests) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 60);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:  stall_next = 1'b0;
          STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
          default:     stall_next = ~out_stall;
        endcase
      end
    end
    out_stall <= stall_next;
  end

  // result checker
  always @(posedge clk) begin
    pip_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (packer_results.size() == 0) begin
        note_mismatch("unexpected transfer", '0, out_item);
      end else begin
        want = packer_results.pop_front();
        if (out_item.result_kind !== want.result_kind ||
            out_item.packed_byte !== want.packed_byte ||
            out_item.palette_slot !== want.palette_slot ||
            out_item.palette_colour !== want.palette_colour ||
            out_item.result_last !== want.result_last)
          note_mismatch("field", want, out_item);
      end
      case (out_item.result_kind)
        pip_pkg::KIND_BYTE:    byte_results++;
        pip_pkg::KIND_PALETTE: palette_results++;
        pip_pkg::KIND_ERROR:   error_results++;
        default:               ;
      endcase
      if (out_item.result_last === 1'b1)
        images_closed++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels taken, %0d results outstanding",
               cycle_count, pixels_taken, packer_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_FIRST_TRANSPARENT)
      cfg_transparent = data[0];
  endtask

  task automatic reg_check(input logic [2:0] addr);
    logic [31:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'b0, cfg_transparent}) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch (register read): expected %08h, got %08h",
                 {31'b0, cfg_transparent}, got);
    end
  endtask

  task automatic send_pixel(input logic [31:0] colour, input logic last);
    pip_pkg::in_item_t px;
    px.pixel_colour = colour;
    px.pixel_last = last;
    pixels_to_send.push_back(px);
    pixels_queued++;
  endtask

  // n_distinct colours shown once up front, then random picks, rarely any colour
  task automatic send_image(input int unsigned len, input int unsigned n_distinct,
                            input bit close);
    logic [31:0] colours[$];
    logic [31:0] c;
    bit          dup;
    int unsigned k;
    while (colours.size() < n_distinct) begin
      case ($urandom_range(0, 9))
        0:       c = '0;
        1:       c = '1;
        default: c = $urandom();
      endcase
      dup = 1'b0;
      foreach (colours[i]) if (colours[i] == c) dup = 1'b1;
      if (!dup) colours.push_back(c);
    end
    for (k = 0; k < len; k++) begin
      if (k < n_distinct)
        c = colours[k];
      else if ($urandom_range(0, 19) == 0)
        c = $urandom();
      else
        c = colours[$urandom_range(0, n_distinct - 1)];
      send_pixel(c, close && (k == len - 1));
    end
  endtask

  // everything sent, everything owed has come back, then a quiet settling wait
  task automatic wait_drained;
    while (pixels_to_send.size() > 0 || in_valid || packer_results.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n_img;
    int unsigned len;
    int unsigned cap;
    int unsigned nd;
    phase = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    reg_check(ADDR_FIRST_TRANSPARENT);

    // no transparent slot: single pixel, full byte on the last pixel, errors
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b1);
    // fifth colour mid image, the rest of the image is dropped
    send_pixel(32'h1111_1111, 1'b0);
    send_pixel(32'h2222_2222, 1'b0);
    send_pixel(32'h3333_3333, 1'b0);
    send_pixel(32'h4444_4444, 1'b0);
    send_pixel(32'h5555_5555, 1'b0);
    send_pixel(32'h1111_1111, 1'b0);
    send_pixel(32'h6666_6666, 1'b0);
    send_pixel(32'h2222_2222, 1'b1);
    // fifth colour on the last pixel
    send_pixel(32'hAAAA_AAAA, 1'b0);
    send_pixel(32'h5555_5555, 1'b0);
    send_pixel(32'h0123_4567, 1'b0);
    send_pixel(32'h89AB_CDEF, 1'b0);
    send_pixel(32'hFEDC_BA98, 1'b1);
    wait_drained();

    // slot 0 reserved: a zero pixel must take a fresh slot
    reg_write(ADDR_FIRST_TRANSPARENT, 32'h0000_0001);
    reg_check(ADDR_FIRST_TRANSPARENT);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'h0000_0002, 1'b0);
    send_pixel(32'h0000_0003, 1'b0);
    send_pixel(32'h0000_0004, 1'b1);
    wait_drained();

    // write to an unused register is ignored
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFE);
    reg_check(ADDR_FIRST_TRANSPARENT);

    while (pixels_queued < TOTAL_PIXELS) begin
      phase++;
      reg_write(ADDR_FIRST_TRANSPARENT, $urandom());
      if ($urandom_range(0, 5) == 0)
        reg_write(ADDR_UNUSED, $urandom());
      if ($urandom_range(0, 3) == 0)
        reg_check(ADDR_FIRST_TRANSPARENT);
      // long receiver hold while a big image keeps coming
      if (phase == 2 || $urandom_range(0, 7) == 0) begin
        hold_requests++;
        send_image(40, $urandom_range(1, 3), 1'b1);
      end
      n_img = $urandom_range(1, 5);
      for (int i = 0; i < n_img; i++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        cap = cfg_transparent ? pip_pkg::PAL_SLOTS - 1 : pip_pkg::PAL_SLOTS;
        nd = ($urandom_range(0, 6) == 0) ? cap + $urandom_range(1, 2) : $urandom_range(1, cap);
        // sometimes leave the image open across a register write
        send_image(len, nd, (i < n_img - 1) || ($urandom_range(0, 3) != 0));
      end
      wait_drained();
    end
    send_pixel($urandom(), 1'b1);
    wait_drained();

    $display("%0d pixels over %0d random phases: %0d bytes, %0d palette entries, %0d errors",
             pixels_taken, phase, byte_results, palette_results, error_results);
    $display("%0d images closed, %0d long receiver holds, %0d mismatches",
             images_closed, holds_done, mismatches);
    if (mismatches == 0 && packer_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/pip_pkg.sv
rtl/pip_pack.sv
rtl/pip_emit.sv
rtl/palette_index_packer_2bpp.sv
bench/palette_index_packer_2bpp_tb.sv
